### rtl/dsi_pkg.sv
`default_nettype none

package dsi_pkg;

  localparam int unsigned Q_W        = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned LANE_W     = 16;
  localparam int unsigned XYZ_W      = 48;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned SAT_IN_W   = 56;

  localparam logic [COEF_W-1:0] SPRING_COEF_RST = 16'd256;
  localparam logic [COEF_W-1:0] INV_MASS_RST    = 16'd256;
  localparam logic [COEF_W-1:0] DAMPING_RST     = 16'd0;
  localparam logic [THR_W-1:0]  SETTLE_THR_RST  = 31'd655;

  typedef enum logic [PHASE_W-1:0] {
    PH_START   = 2'd0,
    PH_MOVING  = 2'd1,
    PH_SETTLED = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRING_COEF = 3'd0,
    CFG_REST_LENGTH = 3'd1,
    CFG_INV_MASS    = 3'd2,
    CFG_DAMPING     = 3'd3,
    CFG_GRAVITY     = 3'd4,
    CFG_START_POS   = 3'd5,
    CFG_SETTLE_THR  = 3'd6
  } cfg_reg_e;

  // Clamp a wide signed value to the signed Q16.16 range.
  function automatic logic signed [Q_W-1:0] sat_q32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if ((&v[SAT_IN_W-1:Q_W-1]) || !(|v[SAT_IN_W-1:Q_W-1])) begin
      r = v[Q_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/dsi_in_if.sv
`default_nettype none

interface dsi_in_if;
  import dsi_pkg::*;

  logic            valid;
  logic            ready;
  logic [DT_W-1:0] delta_time;

  modport source (output valid, output delta_time, input ready);
  modport sink   (input valid, input delta_time, output ready);
endinterface

`default_nettype wire

### rtl/dsi_out_if.sv
`default_nettype none

interface dsi_out_if;
  import dsi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [Q_W-1:0]    pos_x;
  logic signed [Q_W-1:0]    pos_y;
  logic signed [Q_W-1:0]    pos_z;
  logic        [PHASE_W-1:0] phase;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output phase,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input phase,
                  output ready);
endinterface

`default_nettype wire

### rtl/damped_spring_integrator.sv
// Damped spring integrator: one Euler step of a 3-axis mass on a spring per frame tick.
// in_i carries one tick (delta_time, unsigned Q0.16) per transaction; out_o returns one
// transaction per tick with the position (signed Q16.16 per axis) and the phase after it.
// The cfg_* port writes one register per cycle while cfg_we_i is high; the user must write it
// only while the block is idle, which the block itself does not enforce. Unknown register indexes are ignored.
// A tick in the start or settled phase needs no arithmetic: it goes straight to the done step.
// A tick in the moving phase runs a sequencer over one shared 17x45-bit multiplier, 9 steps
// per axis, before the done step. in_i is ready only while the sequencer is idle, so the block
// takes no new tick until the done step has passed the last one on.
// A finished result sits in the output register; the block goes back to idle and accepts the
// next tick while that result is still waiting, and only stalls at the end of the next tick
// if the receiver has not taken it by then.
// Reset clears position, velocity and phase (start) and loads the register defaults.
`default_nettype none

module damped_spring_integrator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dsi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dsi_in_if.sink                           in_i,
  dsi_out_if.source                        out_o
);
  import dsi_pkg::*;

  localparam int unsigned MA_W   = COEF_W + 1;
  localparam int unsigned T_W    = 45;
  localparam int unsigned PROD_W = MA_W + T_W;
  localparam int unsigned SHR_W  = PROD_W - 8;
  localparam int unsigned F_W    = SHR_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MUL_K, ST_MUL_D, ST_DRAG, ST_MUL_M, ST_FORCE, ST_MUL_T,
    ST_VEL, ST_POS, ST_DONE
  } st_e;

  // Configuration registers.
  logic        [COEF_W-1:0] spring_q, inv_mass_q, damping_q;
  logic signed [Q_W-1:0]    rest_q;
  logic        [XYZ_W-1:0]  gravity_q, start_pos_q;
  logic        [THR_W-1:0]  thr_q;

  st_e                    state_q;
  phase_e                 phase_q;
  logic [AXIS_W-1:0]      axis_q;
  logic                   settled_q;
  logic signed [Q_W-1:0]  pos_q [NUM_AXES];
  logic signed [Q_W-1:0]  vel_q [NUM_AXES];
  logic                   out_valid_q;
  logic signed [Q_W-1:0]  out_pos_q [NUM_AXES];
  phase_e                 out_phase_q;

  logic [DT_W-1:0]        dt_q;
  logic signed [T_W-1:0]  t_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic signed [MA_W-1:0] mul_a;
  logic signed [T_W-1:0]  mul_b;
  logic signed [Q_W-1:0]  pos_sel, vel_sel, grav256, f_sat, accel;
  logic signed [SHR_W-1:0] shr8;
  logic signed [F_W-1:0]  force_sum;
  logic signed [Q_W:0]    vel_sum, pos_sum, accel_ext;
  logic        [Q_W-1:0]  accel_mag;
  logic [LANE_W-1:0]      grav_lane;
  logic                   in_fire, out_fire;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = out_pos_q[0];
  assign out_o.pos_y = out_pos_q[1];
  assign out_o.pos_z = out_pos_q[2];
  assign out_o.phase = out_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q    <= SPRING_COEF_RST;
      rest_q      <= '0;
      inv_mass_q  <= INV_MASS_RST;
      damping_q   <= DAMPING_RST;
      gravity_q   <= '0;
      start_pos_q <= '0;
      thr_q       <= SETTLE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SPRING_COEF: spring_q    <= cfg_data_i[COEF_W-1:0];
        CFG_REST_LENGTH: rest_q      <= cfg_data_i[Q_W-1:0];
        CFG_INV_MASS:    inv_mass_q  <= cfg_data_i[COEF_W-1:0];
        CFG_DAMPING:     damping_q   <= cfg_data_i[COEF_W-1:0];
        CFG_GRAVITY:     gravity_q   <= cfg_data_i[XYZ_W-1:0];
        CFG_START_POS:   start_pos_q <= cfg_data_i[XYZ_W-1:0];
        CFG_SETTLE_THR:  thr_q       <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection and the per-step adders.
  always_comb begin
    pos_sel   = pos_q[axis_q];
    vel_sel   = vel_q[axis_q];
    grav_lane = gravity_q[LANE_W*axis_q +: LANE_W];
    grav256   = {{(Q_W-LANE_W-8){grav_lane[LANE_W-1]}}, grav_lane, 8'b0};

    case (state_q)
      ST_MUL_K: begin
        mul_a = $signed({1'b0, spring_q});
        mul_b = t_q;
      end
      ST_MUL_D: begin
        mul_a = $signed({1'b0, damping_q});
        mul_b = T_W'(vel_sel);
      end
      ST_MUL_M: begin
        mul_a = $signed({1'b0, inv_mass_q});
        mul_b = t_q;
      end
      ST_MUL_T: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = t_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;

    // Dropping low bits of the two's complement product rounds toward minus infinity.
    shr8      = prod_q[PROD_W-1:8];
    force_sum = F_W'(shr8) + F_W'(grav256);
    f_sat     = sat_q32(SAT_IN_W'(force_sum));

    // f fits 32 bits and dt is below one, so the scaled step also fits 32 bits.
    accel     = prod_q[Q_W+15:16];
    accel_ext = (Q_W+1)'(accel);
    accel_mag = accel[Q_W-1] ? Q_W'(-accel_ext) : Q_W'(accel_ext);
    vel_sum   = (Q_W+1)'(vel_sel) + accel_ext;
    pos_sum   = (Q_W+1)'(pos_sel) + (Q_W+1)'(vel_sel);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_fire) begin
      dt_q <= in_i.delta_time;
    end
    case (state_q)
      ST_DIFF:  t_q <= T_W'(pos_sel) - T_W'(rest_q);
      ST_MUL_D: t_q <= -T_W'(shr8);
      ST_DRAG:  t_q <= t_q - T_W'(shr8);
      ST_FORCE: t_q <= T_W'(f_sat);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_START;
      axis_q      <= '0;
      settled_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_phase_q <= PH_START;
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i]     <= '0;
        vel_q[i]     <= '0;
        out_pos_q[i] <= '0;
      end
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (phase_q)
              PH_START: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                  vel_q[i] <= '0;
                  pos_q[i] <= {{(Q_W-LANE_W-8){start_pos_q[LANE_W*i+LANE_W-1]}},
                               start_pos_q[LANE_W*i +: LANE_W], 8'b0};
                end
                phase_q <= PH_MOVING;
                state_q <= ST_DONE;
              end
              PH_MOVING: begin
                axis_q    <= '0;
                settled_q <= 1'b1;
                state_q   <= ST_DIFF;
              end
              default: begin
                phase_q <= PH_START;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIFF:  state_q <= ST_MUL_K;
        ST_MUL_K: state_q <= ST_MUL_D;
        ST_MUL_D: state_q <= ST_DRAG;
        ST_DRAG:  state_q <= ST_MUL_M;
        ST_MUL_M: state_q <= ST_FORCE;
        ST_FORCE: state_q <= ST_MUL_T;
        ST_MUL_T: state_q <= ST_VEL;
        ST_VEL: begin
          vel_q[axis_q] <= sat_q32(SAT_IN_W'(vel_sum));
          if (!(accel_mag < {1'b0, thr_q})) begin
            settled_q <= 1'b0;
          end
          state_q <= ST_POS;
        end
        ST_POS: begin
          pos_q[axis_q] <= sat_q32(SAT_IN_W'(pos_sum));
          if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
            if (settled_q) begin
              phase_q <= PH_SETTLED;
            end
            state_q <= ST_DONE;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= ST_DIFF;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_phase_q <= phase_q;
            for (int i = 0; i < NUM_AXES; i++) begin
              out_pos_q[i] <= pos_q[i];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= AXIS_W'(NUM_AXES - 1))
    else $error("axis counter out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done step");

  a_moving_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_MOVING) |=> (state_q == ST_DIFF && axis_q == '0 && settled_q))
    else $error("moving tick did not start the sequence at the first axis");

  a_start_clears_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_START) |=>
      (vel_q[0] == '0 && vel_q[1] == '0 && vel_q[2] == '0 && phase_q == PH_MOVING))
    else $error("start tick did not clear velocity");

  a_settle_at_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SETTLED && $past(phase_q) == PH_MOVING) |->
      $past(state_q == ST_POS && settled_q))
    else $error("settled phase entered outside the last position update");

endmodule

`default_nettype wire

### tb/tb_damped_spring_integrator.sv
`default_nettype none

module tb_damped_spring_integrator;
  timeunit 1ns;
  timeprecision 1ps;

  import dsi_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned PHASE_TICKS     = 129;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum int unsigned {RX_STREAM, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic [COEF_W-1:0]       spring_k;
    logic signed [Q_W-1:0]   rest_len;
    logic [COEF_W-1:0]       inv_mass;
    logic [COEF_W-1:0]       damp;
    logic [XYZ_W-1:0]        gravity;
    logic [XYZ_W-1:0]        start_pos;
    logic [THR_W-1:0]        settle_thr;
  } spring_cfg_t;

  typedef struct {
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] pos_z;
    phase_e                phase;
  } frame_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dsi_in_if  in_if ();
  dsi_out_if out_if ();

  damped_spring_integrator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state, mirrored from the block's registers and integrator.
  spring_cfg_t active_cfg;
  longint      model_pos [NUM_AXES];
  longint      model_vel [NUM_AXES];
  phase_e      model_phase;

  frame_t      expected_frames [$];
  int unsigned ticks_sent, results_checked, settle_events, settings_used, error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          hold_off_req;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint clamp_q32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lane_q88(logic [XYZ_W-1:0] xyz, int axis);
    logic signed [LANE_W-1:0] l;
    l = xyz[LANE_W*axis +: LANE_W];
    return longint'(l);
  endfunction

  task automatic model_reset();
    active_cfg.spring_k   = SPRING_COEF_RST;
    active_cfg.rest_len   = '0;
    active_cfg.inv_mass   = INV_MASS_RST;
    active_cfg.damp       = DAMPING_RST;
    active_cfg.gravity    = '0;
    active_cfg.start_pos  = '0;
    active_cfg.settle_thr = SETTLE_THR_RST;
    for (int i = 0; i < NUM_AXES; i++) begin
      model_pos[i] = 0;
      model_vel[i] = 0;
    end
    model_phase = PH_START;
  endtask

  // One Euler step of the spring; every arithmetic shift here rounds toward minus infinity.
  function automatic frame_t integrate_tick(logic [DT_W-1:0] dt);
    frame_t r;
    longint ks, ms, ds, thr, dtl, rest, disp, tension, drag, net_force, accel, mag;
    bit     all_quiet;
    ks   = active_cfg.spring_k;
    ms   = active_cfg.inv_mass;
    ds   = active_cfg.damp;
    thr  = active_cfg.settle_thr;
    rest = active_cfg.rest_len;
    dtl  = dt;
    case (model_phase)
      PH_START: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          model_vel[i] = 0;
          model_pos[i] = lane_q88(active_cfg.start_pos, i) * 256;
        end
        model_phase = PH_MOVING;
      end
      PH_MOVING: begin
        all_quiet = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
          disp      = model_pos[i] - rest;
          tension   = -((ks * disp) >>> 8);
          drag      = (ds * model_vel[i]) >>> 8;
          net_force = (ms * (tension - drag)) >>> 8;
          net_force = clamp_q32(net_force + lane_q88(active_cfg.gravity, i) * 256);
          accel     = (net_force * dtl) >>> 16;
          model_vel[i] = clamp_q32(model_vel[i] + accel);
          model_pos[i] = clamp_q32(model_pos[i] + model_vel[i]);
          mag = (accel < 0) ? -accel : accel;
          if (!(mag < thr)) all_quiet = 1'b0;
        end
        if (all_quiet) begin
          model_phase = PH_SETTLED;
          settle_events++;
        end
      end
      default: model_phase = PH_START;
    endcase
    r.pos_x = model_pos[0][Q_W-1:0];
    r.pos_y = model_pos[1][Q_W-1:0];
    r.pos_z = model_pos[2][Q_W-1:0];
    r.phase = model_phase;
    return r;
  endfunction

  // Leaves the write enable high; apply_setting lowers it after the last register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Bits above each register's width carry junk, which the block must drop.
  task automatic apply_setting(spring_cfg_t c);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_SPRING_COEF, {junk[47:16], c.spring_k});
    write_reg(CFG_REST_LENGTH, {junk[47:32], c.rest_len});
    write_reg(CFG_INV_MASS,    {junk[31:0], c.inv_mass});
    write_reg(CFG_DAMPING,     {junk[63:32], c.damp});
    write_reg(CFG_GRAVITY,     c.gravity);
    write_reg(CFG_START_POS,   c.start_pos);
    write_reg(CFG_SETTLE_THR,  {junk[16:0], c.settle_thr});
    write_reg(CFG_UNUSED_IDX,  junk[CFG_DATA_W-1:0]);
    cfg_we_i <= 1'b0;
    active_cfg = c;
    settings_used++;
  endtask

  task automatic send_tick(logic [DT_W-1:0] dt);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.delta_time <= dt;
    do @(posedge clk_i); while (!in_if.ready);
    expected_frames.push_back(integrate_tick(dt));
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Waits until every expected frame has come back and the sequencer has gone quiet.
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic spring_cfg_t random_setting(bit wild);
    spring_cfg_t c;
    int          r;
    if (wild) begin
      c.spring_k   = COEF_W'($urandom);
      c.rest_len   = $urandom;
      c.inv_mass   = COEF_W'($urandom);
      c.damp       = COEF_W'($urandom);
      c.gravity    = XYZ_W'({$urandom, $urandom});
      c.start_pos  = XYZ_W'({$urandom, $urandom});
      c.settle_thr = THR_W'($urandom);
    end else begin
      r = int'($urandom_range(0, 8388608)) - 4194304;
      c.spring_k   = COEF_W'($urandom_range(0, 1024));
      c.rest_len   = r;
      c.inv_mass   = COEF_W'($urandom_range(16, 512));
      c.damp       = COEF_W'($urandom_range(0, 4096));
      for (int i = 0; i < NUM_AXES; i++)
        c.gravity[LANE_W*i +: LANE_W] = 16'($urandom_range(0, 1024) - 512);
      c.start_pos  = XYZ_W'({$urandom, $urandom});
      c.settle_thr = THR_W'($urandom_range(0, 1048576));
    end
    return c;
  endfunction

  task automatic test_reset_defaults();
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h1234);
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    drain_block();
  endtask

  // Everything at full scale with a zero threshold: the integrator saturates and never settles.
  task automatic test_saturation_corners();
    spring_cfg_t c;
    c.spring_k   = 16'hFFFF;
    c.rest_len   = 32'sh8000_0000;
    c.inv_mass   = 16'hFFFF;
    c.damp       = 16'hFFFF;
    c.gravity    = {16'hFFFF, 16'h8000, 16'h7FFF};
    c.start_pos  = {16'h0001, 16'h8000, 16'h7FFF};
    c.settle_thr = '0;
    apply_setting(c);
    repeat (6) send_tick(16'hFFFF);
    send_tick(16'h0000);
    drain_block();
  endtask

  // A full-scale threshold settles on every moving tick, so the phases cycle quickly.
  task automatic test_instant_settle();
    spring_cfg_t c;
    c.spring_k   = '0;
    c.rest_len   = 32'sh7FFF_FFFF;
    c.inv_mass   = '0;
    c.damp       = '0;
    c.gravity    = {16'h8000, 16'h7FFF, 16'h7FFF};
    c.start_pos  = {16'hFFFF, 16'h0000, 16'h8000};
    c.settle_thr = 31'h7FFF_FFFF;
    apply_setting(c);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'h0001);
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h8000);
    drain_block();
  endtask

  task automatic test_time_step_extremes();
    spring_cfg_t c;
    c.spring_k   = 16'h0100;
    c.rest_len   = '0;
    c.inv_mass   = 16'h0100;
    c.damp       = 16'h0080;
    c.gravity    = {16'h0000, 16'h0000, 16'hFF00};
    c.start_pos  = {16'h7FFF, 16'hFB00, 16'h0A00};
    c.settle_thr = 31'd655;
    apply_setting(c);
    send_tick(16'h0000);
    send_tick(16'h0001);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    send_tick(16'hFFFF);
    drain_block();
  endtask

  // Most settings are physically sensible so the spring settles and restarts;
  // about one in four uses full-range registers and time steps.
  task automatic test_random_settings(int unsigned phases);
    bit wild;
    for (int p = 0; p < phases; p++) begin
      wild = ($urandom_range(0, 3) == 0);
      apply_setting(random_setting(wild));
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (wild || $urandom_range(0, 7) == 0) send_tick(DT_W'($urandom_range(0, 65535)));
        else send_tick(DT_W'($urandom_range(0, 2048)));
      end
      drain_block();
    end
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the input stalls.
  task automatic test_output_backpressure();
    apply_setting(random_setting(1'b0));
    hold_off_req = 1'b1;
    repeat (40) send_tick(DT_W'($urandom_range(0, 4096)));
    drain_block();
  endtask

  initial begin : rx_ready_gen
    rx_mode_e    mode;
    int unsigned seg_len;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        seg_len = $urandom_range(20, 200);
        for (int k = 0; k < seg_len && !hold_off_req; k++) begin
          case (mode)
            RX_STREAM:   out_if.ready <= 1'b1;
            RX_COIN:     out_if.ready <= $urandom_range(0, 1);
            RX_PERIODIC: out_if.ready <= (k % 4) != 3;
            default:     out_if.ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : frame_checker
    frame_t exp_f;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_frames.size() == 0) begin
        $error("Result transaction arrived with no tick outstanding");
        error_count++;
      end else begin
        exp_f = expected_frames.pop_front();
        results_checked++;
        if (out_if.pos_x !== exp_f.pos_x) begin
          $error("pos_x mismatch: expected %0d, got %0d", exp_f.pos_x, out_if.pos_x);
          error_count++;
        end
        if (out_if.pos_y !== exp_f.pos_y) begin
          $error("pos_y mismatch: expected %0d, got %0d", exp_f.pos_y, out_if.pos_y);
          error_count++;
        end
        if (out_if.pos_z !== exp_f.pos_z) begin
          $error("pos_z mismatch: expected %0d, got %0d", exp_f.pos_z, out_if.pos_z);
          error_count++;
        end
        if (out_if.phase !== exp_f.phase) begin
          $error("phase mismatch: expected %0d, got %0d", exp_f.phase, out_if.phase);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d frames still outstanding",
             cycle_count, expected_frames.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : test_sequence
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    in_if.valid      <= 1'b0;
    in_if.delta_time <= '0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_saturation_corners();
    test_instant_settle();
    test_time_step_extremes();
    test_random_settings(6);
    test_output_backpressure();
    test_random_settings(4);
    drain_block();

    $display("Integrated %0d frame ticks under %0d register settings; %0d results checked.",
             ticks_sent, settings_used, results_checked);
    $display("The spring settled %0d times; saturating and zero time steps and a %0d-cycle %s",
             settle_events, HOLD_OFF_CYCLES, "output stall were exercised.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
